// ----- rtl/sha1bs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha1bs_pkg
// Shared constants, types and round constants for the byte-stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1bs_pkg;

    localparam int WORD_W      = 32;
    localparam int BLK_WORDS   = 16;
    localparam int BLK_AW      = 4;
    localparam int RND_W       = 7;
    localparam int DIGEST_N    = 5;
    localparam int IDX_W       = 3;
    localparam int LEN_W       = 64;
    localparam int POS_W       = 6;
    localparam int LCNT_W      = 4;

    localparam logic [RND_W-1:0] ROUND_LAST  = 7'd79;
    localparam logic [RND_W-1:0] SCHED_START = 7'd16;
    localparam logic [RND_W-1:0] F1_END      = 7'd20;
    localparam logic [RND_W-1:0] F2_END      = 7'd40;
    localparam logic [RND_W-1:0] F3_END      = 7'd60;

    localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

    localparam logic [WORD_W-1:0] H_INIT [DIGEST_N] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Byte positions inside a 64-byte block.
    localparam logic [POS_W-1:0]  BLK_LAST_POS = 6'd63;
    localparam logic [POS_W-1:0]  LEN_POS      = 6'd56;
    localparam logic [7:0]        PAD_BYTE     = 8'h80;
    localparam logic [LCNT_W-1:0] LEN_BYTES    = 4'd8;
    localparam logic [IDX_W-1:0]  LAST_IDX     = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } work_t;

    typedef struct packed {
        logic              load_en;
        logic [BLK_AW-1:0] load_addr;
        logic [WORD_W-1:0] load_word;
        logic [RND_W-1:0]  rd_rnd;
        logic [RND_W-1:0]  cur_rnd;
        logic              expand_en;
    } sched_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/sha1bs_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha1bs_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module sha1bs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr0,
    input  wire logic [AW-1:0]    raddr1,
    output logic      [WIDTH-1:0] rdata0,
    output logic      [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

// ----- rtl/sha1bs_sched.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha1bs_sched
// Message block store and in-place schedule expansion over two RAM copies.
// ----------------------------------------------------------------------------
module sha1bs_sched (
    input  wire logic                          clk,
    input  wire sha1bs_pkg::sched_ctl_t        ctl,
    output logic [sha1bs_pkg::WORD_W-1:0]      w
);

    logic [sha1bs_pkg::BLK_AW-1:0] rn;
    logic [sha1bs_pkg::BLK_AW-1:0] waddr;
    logic [sha1bs_pkg::WORD_W-1:0] wdata;
    logic                          we;
    logic [sha1bs_pkg::WORD_W-1:0] a0, a1, b0, b1;
    logic [sha1bs_pkg::WORD_W-1:0] mix;

    // Both copies take every write, so together they give four read ports:
    // W[t-3], W[t-8], W[t-14] and W[t-16] for the round issued next.
    assign rn    = ctl.rd_rnd[sha1bs_pkg::BLK_AW-1:0];
    assign we    = ctl.load_en | ctl.expand_en;
    assign waddr = ctl.load_en ? ctl.load_addr : ctl.cur_rnd[sha1bs_pkg::BLK_AW-1:0];
    assign wdata = ctl.load_en ? ctl.load_word : w;

    sha1bs_ram #(
        .WIDTH (sha1bs_pkg::WORD_W),
        .DEPTH (sha1bs_pkg::BLK_WORDS)
    ) u_ram_a (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (rn + 4'd13),
        .raddr1 (rn + 4'd8),
        .rdata0 (a0),
        .rdata1 (a1)
    );

    sha1bs_ram #(
        .WIDTH (sha1bs_pkg::WORD_W),
        .DEPTH (sha1bs_pkg::BLK_WORDS)
    ) u_ram_b (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (rn + 4'd2),
        .raddr1 (rn),
        .rdata0 (b0),
        .rdata1 (b1)
    );

    assign mix = a0 ^ a1 ^ b0 ^ b1;
    assign w   = (ctl.cur_rnd < sha1bs_pkg::SCHED_START) ? b1
                                                        : {mix[30:0], mix[31]};

endmodule
`default_nettype wire

// ----- rtl/sha1bs_round.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha1bs_round
// One SHA-1 compression round: round function, constant and the a..e update.
// ----------------------------------------------------------------------------
module sha1bs_round (
    input  wire sha1bs_pkg::work_t              cur,
    input  wire logic [sha1bs_pkg::RND_W-1:0]   rnd,
    input  wire logic [sha1bs_pkg::WORD_W-1:0]  w,
    output sha1bs_pkg::work_t                   nxt
);

    logic [sha1bs_pkg::WORD_W-1:0] f;
    logic [sha1bs_pkg::WORD_W-1:0] k;

    always_comb
    begin
        if (rnd < sha1bs_pkg::F1_END)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = sha1bs_pkg::K_0;
        end
        else if (rnd < sha1bs_pkg::F2_END)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1bs_pkg::K_1;
        end
        else if (rnd < sha1bs_pkg::F3_END)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = sha1bs_pkg::K_2;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = sha1bs_pkg::K_3;
        end
    end

    always_comb
    begin
        nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule
`default_nettype wire

// ----- rtl/sha1_byte_stream_hasher_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit
// SHA-1 hasher that takes message bytes one transfer at a time.
// ----------------------------------------------------------------------------
// A transfer with no finish is absorbed in idle, except that the byte
// completing a 64-byte block starts a compression: a load step loads a..e,
// 80 rounds run at one round per cycle, with each schedule word read from
// the block RAM in the cycle before its round and expanded in place, and an
// add step adds the result into the chaining words. Input is ready only
// between items. A finish transfer then pads one byte per cycle outside the
// compressions (9 to 72 pad bytes), with one or two compressions along the
// way, and the digest leaves as five output transfers, word 0 first; after
// the fifth the chaining words return to the standard initial values.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_valid,
    input  wire logic        finish,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_COMP,
        S_ADD,
        S_OUT
    } state_t;

    state_t                                state_reg, state_next;
    logic [sha1bs_pkg::LEN_W-1:0]          bit_len_reg, bit_len_next;
    logic [sha1bs_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [sha1bs_pkg::WORD_W-1:0]         acc_reg, acc_next;
    logic [sha1bs_pkg::WORD_W-1:0]         chain_reg [sha1bs_pkg::DIGEST_N];
    logic [sha1bs_pkg::WORD_W-1:0]         chain_next [sha1bs_pkg::DIGEST_N];
    sha1bs_pkg::work_t                     work_reg, work_next;
    logic [sha1bs_pkg::RND_W-1:0]          rnd_reg, rnd_next;
    logic                                  pad_active_reg, pad_active_next;
    logic                                  sent80_reg, sent80_next;
    logic [sha1bs_pkg::LCNT_W-1:0]         len_cnt_reg, len_cnt_next;
    logic [sha1bs_pkg::IDX_W-1:0]          out_idx_reg, out_idx_next;

    logic                                  absorb_en;
    logic [7:0]                            absorb_byte;
    logic [sha1bs_pkg::POS_W-1:0]          pos;
    logic [sha1bs_pkg::WORD_W-1:0]         acc_merge;
    logic                                  blk_full;
    logic                                  len_phase;
    logic [sha1bs_pkg::RND_W-1:0]          rd_rnd;
    sha1bs_pkg::sched_ctl_t                sched_ctl;
    logic [sha1bs_pkg::WORD_W-1:0]         sched_w;
    sha1bs_pkg::work_t                     round_out;

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = chain_reg[out_idx_reg];
    assign word_index  = out_idx_reg;
    assign last_word   = (out_idx_reg == sha1bs_pkg::LAST_IDX);

    assign pos       = bit_len_reg[8:3];
    assign len_phase = (len_cnt_reg != '0) || (pos == sha1bs_pkg::LEN_POS);

    // Byte source: the input in idle, the pad sequencer while padding.
    always_comb
    begin
        absorb_en   = 1'b0;
        absorb_byte = '0;
        case (state_reg)
            S_IDLE:
            begin
                absorb_en   = in_valid & byte_valid;
                absorb_byte = data_byte;
            end
            S_PAD:
            begin
                absorb_en = 1'b1;
                if (!sent80_reg)
                begin
                    absorb_byte = sha1bs_pkg::PAD_BYTE;
                end
                else if (!len_phase)
                begin
                    absorb_byte = '0;
                end
                else
                begin
                    absorb_byte = len_reg[{~len_cnt_reg[2:0], 3'b000} +: 8];
                end
            end
            default:
            begin
                absorb_en   = 1'b0;
                absorb_byte = '0;
            end
        endcase
    end

    // Bytes are packed big-endian; a word goes to the RAM once it is full.
    always_comb
    begin
        case (pos[1:0])
            2'd0:    acc_merge = {absorb_byte, 24'h000000};
            2'd1:    acc_merge = {acc_reg[31:24], absorb_byte, 16'h0000};
            2'd2:    acc_merge = {acc_reg[31:16], absorb_byte, 8'h00};
            2'd3:    acc_merge = {acc_reg[31:8], absorb_byte};
            default: acc_merge = acc_reg;
        endcase
    end

    assign blk_full = absorb_en && (pos == sha1bs_pkg::BLK_LAST_POS);

    assign rd_rnd = (state_reg == S_COMP) ? rnd_reg + 7'd1 : '0;

    always_comb
    begin
        sched_ctl.load_en   = absorb_en && (pos[1:0] == 2'd3);
        sched_ctl.load_addr = pos[5:2];
        sched_ctl.load_word = acc_merge;
        sched_ctl.rd_rnd    = rd_rnd;
        sched_ctl.cur_rnd   = rnd_reg;
        sched_ctl.expand_en = (state_reg == S_COMP) && (rnd_reg >= sha1bs_pkg::SCHED_START);
    end

    sha1bs_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .w   (sched_w)
    );

    sha1bs_round u_round (
        .cur (work_reg),
        .rnd (rnd_reg),
        .w   (sched_w),
        .nxt (round_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        bit_len_next    = bit_len_reg;
        len_next        = len_reg;
        acc_next        = acc_reg;
        chain_next      = chain_reg;
        work_next       = work_reg;
        rnd_next        = rnd_reg;
        pad_active_next = pad_active_reg;
        sent80_next     = sent80_reg;
        len_cnt_next    = len_cnt_reg;
        out_idx_next    = out_idx_reg;

        if (absorb_en)
        begin
            acc_next     = acc_merge;
            bit_len_next = bit_len_reg + 64'd8;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (finish)
                    begin
                        pad_active_next = 1'b1;
                        sent80_next     = 1'b0;
                        len_cnt_next    = '0;
                        // The appended length counts the finish byte, if any.
                        len_next        = byte_valid ? bit_len_reg + 64'd8 : bit_len_reg;
                    end
                    if (blk_full)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (finish)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (!sent80_reg)
                begin
                    sent80_next = 1'b1;
                end
                else if (len_phase)
                begin
                    len_cnt_next = len_cnt_reg + 4'd1;
                end
                if (blk_full)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                work_next.a = chain_reg[0];
                work_next.b = chain_reg[1];
                work_next.c = chain_reg[2];
                work_next.d = chain_reg[3];
                work_next.e = chain_reg[4];
                rnd_next    = '0;
                state_next  = S_COMP;
            end
            S_COMP:
            begin
                work_next = round_out;
                if (rnd_reg == sha1bs_pkg::ROUND_LAST)
                begin
                    rnd_next   = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                if (!pad_active_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (len_cnt_reg == sha1bs_pkg::LEN_BYTES)
                begin
                    out_idx_next = '0;
                    state_next   = S_OUT;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (out_idx_reg == sha1bs_pkg::LAST_IDX)
                    begin
                        for (int i = 0; i < sha1bs_pkg::DIGEST_N; i++)
                        begin
                            chain_next[i] = sha1bs_pkg::H_INIT[i];
                        end
                        bit_len_next    = '0;
                        pad_active_next = 1'b0;
                        out_idx_next    = '0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bit_len_reg    <= '0;
            len_reg        <= '0;
            acc_reg        <= '0;
            for (int i = 0; i < sha1bs_pkg::DIGEST_N; i++)
            begin
                chain_reg[i] <= sha1bs_pkg::H_INIT[i];
            end
            work_reg       <= '0;
            rnd_reg        <= '0;
            pad_active_reg <= 1'b0;
            sent80_reg     <= 1'b0;
            len_cnt_reg    <= '0;
            out_idx_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_len_reg    <= bit_len_next;
            len_reg        <= len_next;
            acc_reg        <= acc_next;
            chain_reg      <= chain_next;
            work_reg       <= work_next;
            rnd_reg        <= rnd_next;
            pad_active_reg <= pad_active_next;
            sent80_reg     <= sent80_next;
            len_cnt_reg    <= len_cnt_next;
            out_idx_reg    <= out_idx_next;
        end
    end

    // The digest is only shown once padding has closed a whole block.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bit_len_reg[8:0] == '0) && (len_cnt_reg == sha1bs_pkg::LEN_BYTES))
        else $error("digest shown before padding completed a block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMP) |-> (rnd_reg <= sha1bs_pkg::ROUND_LAST))
        else $error("round counter ran past the last round");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (pos == '0))
        else $error("compression started on a partial block");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAD) |-> pad_active_reg)
        else $error("padding without a pending finish");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> (bit_len_reg == '0) && in_ready)
        else $error("state not reloaded after the last digest word");

endmodule
`default_nettype wire
